### hdl/dhcp_rop_pkg.sv
// package for the dhcp reply option parser
// types, protocol constants and option codes shared by the result interface and the top level
// no dependencies

package dhcp_rop_pkg;

	// message layout
	localparam int unsigned DEF_OPTION_AREA_BYTES = 308;
	localparam int unsigned OPT_BASE              = 240;
	localparam int unsigned ADDR_FIRST            = 16;
	localparam int unsigned ADDR_LAST             = 19;
	localparam int unsigned COOKIE_FIRST          = 236;
	localparam int unsigned COOKIE_LAST           = 239;
	localparam logic [31:0] MAGIC_COOKIE          = 32'h6382_5363;

	// byte values
	localparam logic [7:0] OP_BOOTREPLY = 8'd2;
	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_END      = 8'd255;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] MT_OFFER     = 8'd2;
	localparam logic [7:0] MT_ACK       = 8'd5;

	// captured options: subnet mask, router, dns
	localparam int unsigned SLOT_COUNT = 3;
	localparam logic [7:0] SLOT_CODE [SLOT_COUNT] = '{8'd1, 8'd3, 8'd6};
	localparam logic [2:0] CAPTURE_BYTES = 3'd4;

	// option walk phase
	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_SKIP,
		PH_DONE
	} phase_t;

	// result status
	typedef enum logic [1:0] {
		ST_NOT_REPLY,
		ST_NO_BIND,
		ST_OFFER,
		ST_ACK
	} status_t;

endpackage

### hdl/dhcp_rop_in_if.sv
// request channel carrying one message byte with its framing marks
// depends on nothing but valid/ready handshake conventions

interface dhcp_rop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

### hdl/dhcp_rop_out_if.sv
// result channel carrying the parse status and the captured addresses
// depends on dhcp_rop_pkg for the status type

interface dhcp_rop_out_if;
	logic                  valid;
	logic                  ready;
	dhcp_rop_pkg::status_t status;
	logic [31:0]           ip_address;
	logic [31:0]           subnet_mask;
	logic [31:0]           gateway;
	logic [31:0]           dns_server;

	modport source (output valid, output status, output ip_address, output subnet_mask,
		output gateway, output dns_server, input ready);
	modport sink (input valid, input status, input ip_address, input subnet_mask,
		input gateway, input dns_server, output ready);
endinterface

### hdl/dhcp_reply_option_parser_top.sv
// dhcp reply option parser: one byte per request, one result request per message
// result path: an accepted last byte is held in the input register, then the state update
// writes the result register
// throughput: one byte per cycle; a last byte waits in stage 1 only while the previous result is unread
// reset: arst_n clears all message state and empties the input and result registers
// depends on dhcp_rop_pkg, dhcp_rop_in_if and dhcp_rop_out_if

module dhcp_reply_option_parser_top #(
	parameter int unsigned OPTION_AREA_BYTES = dhcp_rop_pkg::DEF_OPTION_AREA_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	dhcp_rop_in_if.sink   msg,
	dhcp_rop_out_if.source result
);

	localparam int unsigned AREA_END = dhcp_rop_pkg::OPT_BASE + OPTION_AREA_BYTES;
	localparam int unsigned OFFS_W   = $clog2(AREA_END + 1);
	localparam int unsigned NSLOT    = dhcp_rop_pkg::SLOT_COUNT;

	localparam logic [OFFS_W-1:0] OFFS_END      = OFFS_W'(AREA_END);
	localparam logic [OFFS_W-1:0] OFFS_TYPE_MAX = OFFS_W'(AREA_END - 1);
	localparam logic [OFFS_W-1:0] OFFS_CAP_MAX  = OFFS_W'(AREA_END - 5);
	localparam logic [OFFS_W-1:0] OFFS_BASE     = OFFS_W'(dhcp_rop_pkg::OPT_BASE);

	// input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;

	// message state
	logic [OFFS_W-1:0]           offs_q;
	dhcp_rop_pkg::phase_t        phase_q;
	logic [7:0]                  skip_q;
	logic                        reply_q;
	logic                        cookie_ok_q;
	logic [31:0]                 addr_q;
	logic [7:0]                  mtype_q;
	logic                        tpend_q;
	logic [31:0]                 stage_q [NSLOT];
	logic [2:0]                  cnt_q [NSLOT];
	logic [31:0]                 capv_q [NSLOT];

	// next state
	logic [OFFS_W-1:0]           offs_c;
	logic [OFFS_W-1:0]           offs_n;
	dhcp_rop_pkg::phase_t        phase_n;
	logic [7:0]                  skip_n;
	logic                        reply_n;
	logic                        cookie_ok_n;
	logic [31:0]                 addr_n;
	logic [7:0]                  mtype_n;
	logic                        tpend_n;
	logic [31:0]                 stage_n [NSLOT];
	logic [2:0]                  cnt_n [NSLOT];
	logic [31:0]                 capv_n [NSLOT];
	logic [7:0]                  code;
	logic [7:0]                  cookie_byte;

	// result register
	logic                        result_valid_q;
	dhcp_rop_pkg::status_t       status_q;
	logic [31:0]                 ip_q;
	logic [31:0]                 mask_q;
	logic [31:0]                 gw_q;
	logic [31:0]                 dns_q;
	dhcp_rop_pkg::status_t       status_c;

	logic out_free;
	logic s1_fire;

	// handshake: stage 1 stalls only on a last byte whose result slot is busy
	assign out_free  = !result_valid_q || result.ready;
	assign s1_fire   = valid_s1 && (!last_s1 || out_free);
	assign msg.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_s1  <= msg.data_byte;
			first_s1 <= msg.first_byte;
			last_s1  <= msg.last_byte;
		end
	end

	// per-byte state update
	always_comb begin
		// start from held state, or a clean message on the first byte
		if (first_s1) begin
			offs_c      = '0;
			phase_n     = dhcp_rop_pkg::PH_CODE;
			skip_n      = '0;
			reply_n     = 1'b0;
			cookie_ok_n = 1'b1;
			addr_n      = '0;
			mtype_n     = '0;
			tpend_n     = 1'b0;
			for (int k = 0; k < NSLOT; k++) begin
				stage_n[k] = '0;
				cnt_n[k]   = '0;
				capv_n[k]  = '0;
			end
		end else begin
			offs_c      = offs_q;
			phase_n     = phase_q;
			skip_n      = skip_q;
			reply_n     = reply_q;
			cookie_ok_n = cookie_ok_q;
			addr_n      = addr_q;
			mtype_n     = mtype_q;
			tpend_n     = tpend_q;
			for (int k = 0; k < NSLOT; k++) begin
				stage_n[k] = stage_q[k];
				cnt_n[k]   = cnt_q[k];
				capv_n[k]  = capv_q[k];
			end
		end
		code        = skip_n;
		cookie_byte = 8'(dhcp_rop_pkg::MAGIC_COOKIE >> {~offs_c[1:0], 3'b000});

		// fixed header fields
		if (offs_c == '0) begin
			reply_n = (data_s1 == dhcp_rop_pkg::OP_BOOTREPLY);
		end
		if (offs_c >= OFFS_W'(dhcp_rop_pkg::ADDR_FIRST)
				&& offs_c <= OFFS_W'(dhcp_rop_pkg::ADDR_LAST)) begin
			addr_n = {addr_n[23:0], data_s1};
		end
		if (offs_c >= OFFS_W'(dhcp_rop_pkg::COOKIE_FIRST)
				&& offs_c <= OFFS_W'(dhcp_rop_pkg::COOKIE_LAST)
				&& cookie_byte != data_s1) begin
			cookie_ok_n = 1'b0;
		end

		// running four-byte captures
		for (int k = 0; k < NSLOT; k++) begin
			if (cnt_n[k] != '0) begin
				stage_n[k] = {stage_n[k][23:0], data_s1};
				cnt_n[k]   = cnt_n[k] - 3'd1;
				if (cnt_n[k] == '0) begin
					capv_n[k] = stage_n[k];
				end
			end
		end

		// message type byte
		if (tpend_n) begin
			mtype_n = data_s1;
			tpend_n = 1'b0;
		end

		// option walk
		if (offs_c >= OFFS_BASE && offs_c < OFFS_END) begin
			unique case (phase_n)
				dhcp_rop_pkg::PH_CODE: begin
					if (data_s1 == dhcp_rop_pkg::OPT_END) begin
						phase_n = dhcp_rop_pkg::PH_DONE;
					end else if (data_s1 != dhcp_rop_pkg::OPT_PAD) begin
						skip_n  = data_s1;
						phase_n = dhcp_rop_pkg::PH_LEN;
					end
				end
				dhcp_rop_pkg::PH_LEN: begin
					if (code == dhcp_rop_pkg::OPT_MSG_TYPE && offs_c < OFFS_TYPE_MAX) begin
						tpend_n = 1'b1;
					end
					for (int k = 0; k < NSLOT; k++) begin
						if (code == dhcp_rop_pkg::SLOT_CODE[k] && offs_c <= OFFS_CAP_MAX) begin
							stage_n[k] = '0;
							cnt_n[k]   = dhcp_rop_pkg::CAPTURE_BYTES;
						end
					end
					skip_n = data_s1;
					if (data_s1 == '0) begin
						phase_n = dhcp_rop_pkg::PH_CODE;
					end else begin
						phase_n = dhcp_rop_pkg::PH_SKIP;
					end
				end
				dhcp_rop_pkg::PH_SKIP: begin
					if (skip_n != '0) begin
						skip_n = skip_n - 8'd1;
					end
					if (skip_n == '0) begin
						phase_n = dhcp_rop_pkg::PH_CODE;
					end
				end
				dhcp_rop_pkg::PH_DONE: begin
				end
			endcase
		end

		// byte counter saturates past the option area
		offs_n = (offs_c < OFFS_END) ? offs_c + 1'b1 : offs_c;
	end

	// status of a finished message
	always_comb begin
		if (!(offs_n >= OFFS_BASE && cookie_ok_n && reply_n)) begin
			status_c = dhcp_rop_pkg::ST_NOT_REPLY;
		end else if (mtype_n == dhcp_rop_pkg::MT_OFFER) begin
			status_c = dhcp_rop_pkg::ST_OFFER;
		end else if (mtype_n == dhcp_rop_pkg::MT_ACK) begin
			status_c = dhcp_rop_pkg::ST_ACK;
		end else begin
			status_c = dhcp_rop_pkg::ST_NO_BIND;
		end
	end

	// state registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q      <= '0;
			phase_q     <= dhcp_rop_pkg::PH_CODE;
			skip_q      <= '0;
			reply_q     <= 1'b0;
			cookie_ok_q <= 1'b1;
			addr_q      <= '0;
			mtype_q     <= '0;
			tpend_q     <= 1'b0;
			for (int k = 0; k < NSLOT; k++) begin
				stage_q[k] <= '0;
				cnt_q[k]   <= '0;
				capv_q[k]  <= '0;
			end
		end else if (s1_fire) begin
			if (last_s1) begin
				offs_q      <= '0;
				phase_q     <= dhcp_rop_pkg::PH_CODE;
				skip_q      <= '0;
				reply_q     <= 1'b0;
				cookie_ok_q <= 1'b1;
				addr_q      <= '0;
				mtype_q     <= '0;
				tpend_q     <= 1'b0;
				for (int k = 0; k < NSLOT; k++) begin
					stage_q[k] <= '0;
					cnt_q[k]   <= '0;
					capv_q[k]  <= '0;
				end
			end else begin
				offs_q      <= offs_n;
				phase_q     <= phase_n;
				skip_q      <= skip_n;
				reply_q     <= reply_n;
				cookie_ok_q <= cookie_ok_n;
				addr_q      <= addr_n;
				mtype_q     <= mtype_n;
				tpend_q     <= tpend_n;
				for (int k = 0; k < NSLOT; k++) begin
					stage_q[k] <= stage_n[k];
					cnt_q[k]   <= cnt_n[k];
					capv_q[k]  <= capv_n[k];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			status_q <= status_c;
			if (status_c == dhcp_rop_pkg::ST_OFFER || status_c == dhcp_rop_pkg::ST_ACK) begin
				ip_q   <= addr_n;
				mask_q <= capv_n[0];
				gw_q   <= capv_n[1];
				dns_q  <= capv_n[2];
			end else begin
				ip_q   <= '0;
				mask_q <= '0;
				gw_q   <= '0;
				dns_q  <= '0;
			end
		end
	end

	assign result.valid       = result_valid_q;
	assign result.status      = status_q;
	assign result.ip_address  = ip_q;
	assign result.subnet_mask = mask_q;
	assign result.gateway     = gw_q;
	assign result.dns_server  = dns_q;

`ifndef SYNTHESIS
	// a result only appears after a last byte went through stage 1
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without a last byte");

	// unbound results carry no addresses
	a_unbound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (status_q == dhcp_rop_pkg::ST_NOT_REPLY
			|| status_q == dhcp_rop_pkg::ST_NO_BIND)
		|-> ip_q == '0 && mask_q == '0 && gw_q == '0 && dns_q == '0)
		else $error("unbound result with nonzero address");

	// the byte counter stops at the end of the option area
	a_offs_sat: assert property (@(posedge clk) disable iff (!arst_n)
		offs_q <= OFFS_END)
		else $error("byte counter past the option area");

	// an empty input register always takes a request
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> msg.ready)
		else $error("input stalled while stage 1 is empty");
`endif

endmodule
